// ===== hdl/cpt_pkg.sv =====
package cpt_pkg;

  // Table geometry
  localparam int MaxStates = 16;
  localparam int MaxNodes  = 8;
  localparam int CountBits = 16;

  localparam int NodeW    = 3;
  localparam int StateW   = 4;
  localparam int CfgW     = 5;
  localparam int ColAw    = NodeW + StateW;
  localparam int EntAw    = ColAw + StateW;
  localparam int ColDepth = 1 << ColAw;
  localparam int EntDepth = 1 << EntAw;

  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};
  localparam logic [CfgW-1:0]      NumStatesRst = CfgW'(2);

  // Fraction scale: 1.0 is 2^FracBits
  localparam int FracBits = 16;
  localparam int ProbW    = FracBits + 1;
  localparam int DivSteps = FracBits + 1;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } cpt_op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_SAT   = 2'd2
  } cpt_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_DIV,
    S_OUT
  } cpt_state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NodeW-1:0]  node;
    logic [StateW-1:0] hidden_state;
    logic [StateW-1:0] visible_state;
  } cpt_in_t;

  typedef struct packed {
    logic [ProbW-1:0]     probability;
    logic [CountBits-1:0] pair_count;
    logic [CountBits-1:0] column_total;
    logic [1:0]           status;
  } cpt_out_t;

endpackage

// ===== hdl/conditional_probability_table.sv =====
// Count items, empty-column queries: result registered via READ, CALC, OUT. Out-of-range
// and unused-opcode items: READ, OUT; other queries: READ, CALC, DIV (17-step divider), OUT.
// Clear items: READ, CLEAR (the one-entry-a-cycle sweep of the count store), then OUT.
// One item at a time; in_stall_o stays high until the result reaches the output register,
// so the next item is taken in the cycle after at the earliest; output stalls can hold OUT.
// Reset: asynchronous, active low; a clearing pass follows, stall high throughout.
module conditional_probability_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cpt_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  cpt_pkg::cpt_in_t         in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output cpt_pkg::cpt_out_t        out_item_o
);

  // Count store and per-column total store
  logic [cpt_pkg::CountBits-1:0] pair_mem [cpt_pkg::EntDepth];
  logic [cpt_pkg::CountBits-1:0] col_mem  [cpt_pkg::ColDepth];

  cpt_pkg::cpt_state_e           state_q, state_d;
  logic [cpt_pkg::CfgW-1:0]      num_states_q;
  logic [cpt_pkg::EntAw-1:0]     clr_idx_q;
  logic                          clr_op_q, clr_op_d;
  logic                          out_valid_q, out_valid_d;
  cpt_pkg::cpt_in_t              item_q;
  cpt_pkg::cpt_out_t             res_q;
  cpt_pkg::cpt_out_t             out_q;
  logic [cpt_pkg::CountBits-1:0] cnt_rd_q;
  logic [cpt_pkg::CountBits-1:0] tot_rd_q;

  logic [cpt_pkg::ColAw-1:0]     col_addr;
  logic [cpt_pkg::EntAw-1:0]     ent_addr;
  logic                          in_range;
  logic                          accept;
  logic                          out_load;
  logic                          is_count, is_query, is_clear;
  logic                          saturated;
  logic                          div_start;
  logic                          div_done;
  logic [cpt_pkg::ProbW-1:0]     div_quo;

  // Memory write port, shared by the clearing sweep and the count update
  logic                          wr_en;
  logic [cpt_pkg::EntAw-1:0]     wr_ent;
  logic [cpt_pkg::ColAw-1:0]     wr_col;
  logic [cpt_pkg::CountBits-1:0] wr_cnt;
  logic [cpt_pkg::CountBits-1:0] wr_tot;

  assign col_addr = {item_q.node, item_q.hidden_state};
  assign ent_addr = {col_addr, item_q.visible_state};

  // States at or above num_states are out of range; num_states of zero rejects all
  assign in_range = (32'(item_q.node) < cpt_pkg::MaxNodes)
                 && ({1'b0, item_q.hidden_state}  < num_states_q)
                 && ({1'b0, item_q.visible_state} < num_states_q);

  assign is_count  = item_q.opcode == cpt_pkg::OP_COUNT;
  assign is_query  = item_q.opcode == cpt_pkg::OP_QUERY;
  assign is_clear  = item_q.opcode == cpt_pkg::OP_CLEAR;
  assign saturated = tot_rd_q == cpt_pkg::CntMax;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == cpt_pkg::S_OUT) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d  = state_q;
    clr_op_d = clr_op_q;
    unique case (state_q)
      cpt_pkg::S_CLEAR: begin
        if (&clr_idx_q) begin
          state_d  = clr_op_q ? cpt_pkg::S_OUT : cpt_pkg::S_IDLE;
          clr_op_d = 1'b0;
        end
      end
      cpt_pkg::S_IDLE: begin
        if (accept) state_d = cpt_pkg::S_READ;
      end
      cpt_pkg::S_READ: begin
        // Store data for the latched address lands at the end of this cycle
        if (is_clear) begin
          state_d  = cpt_pkg::S_CLEAR;
          clr_op_d = 1'b1;
        end else if ((is_count || is_query) && in_range) begin
          state_d = cpt_pkg::S_CALC;
        end else begin
          state_d = cpt_pkg::S_OUT;
        end
      end
      cpt_pkg::S_CALC: begin
        if (is_query && (tot_rd_q != '0)) state_d = cpt_pkg::S_DIV;
        else                              state_d = cpt_pkg::S_OUT;
      end
      cpt_pkg::S_DIV: begin
        if (div_done) state_d = cpt_pkg::S_OUT;
      end
      cpt_pkg::S_OUT: begin
        if (out_load) state_d = cpt_pkg::S_IDLE;
      end
      default: state_d = cpt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    wr_en      = 1'b0;
    wr_ent     = ent_addr;
    wr_col     = col_addr;
    wr_cnt     = cnt_rd_q + 1'b1;
    wr_tot     = tot_rd_q + 1'b1;
    div_start  = 1'b0;
    unique case (state_q)
      cpt_pkg::S_CLEAR: begin
        wr_en  = 1'b1;
        wr_ent = clr_idx_q;
        wr_col = clr_idx_q[cpt_pkg::ColAw-1:0];
        wr_cnt = '0;
        wr_tot = '0;
      end
      cpt_pkg::S_IDLE: in_stall_o = 1'b0;
      cpt_pkg::S_CALC: begin
        wr_en     = is_count && !saturated;
        div_start = is_query && (tot_rd_q != '0);
      end
      default: ;
    endcase
  end

  cpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cnt_rd_q),
    .den_i   (tot_rd_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cpt_pkg::S_CLEAR;
      num_states_q <= cpt_pkg::NumStatesRst;
      clr_idx_q    <= '0;
      clr_op_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_op_q    <= clr_op_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) num_states_q <= cfg_wdata_i;
      // Advance the sweep; it wraps back to zero at the last entry
      if (state_q == cpt_pkg::S_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // Stores: one write port each, registered read of the addressed entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pair_mem[wr_ent] <= wr_cnt;
      col_mem[wr_col]  <= wr_tot;
    end
    cnt_rd_q <= pair_mem[ent_addr];
    tot_rd_q <= col_mem[col_addr];
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    unique case (state_q)
      cpt_pkg::S_READ: begin
        res_q.probability  <= '0;
        res_q.pair_count   <= '0;
        res_q.column_total <= '0;
        res_q.status       <= ((is_count || is_query) && !in_range) ? cpt_pkg::STS_RANGE
                                                                    : cpt_pkg::STS_OK;
      end
      cpt_pkg::S_CALC: begin
        if (is_count && !saturated) begin
          res_q.pair_count   <= wr_cnt;
          res_q.column_total <= wr_tot;
        end else begin
          res_q.pair_count   <= cnt_rd_q;
          res_q.column_total <= tot_rd_q;
        end
        if (is_count && saturated) res_q.status <= cpt_pkg::STS_SAT;
      end
      cpt_pkg::S_DIV: begin
        if (div_done) res_q.probability <= div_quo;
      end
      default: ;
    endcase
    if (out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/cpt_div.sv =====
// Restoring divider, one quotient bit a cycle: quo = floor(num * 2^FracBits / den).
// Requires num <= den and den != 0, so the quotient fits in ProbW bits.
module cpt_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [cpt_pkg::CountBits-1:0]      num_i,
  input  logic [cpt_pkg::CountBits-1:0]      den_i,
  output logic                               done_o,
  output logic [cpt_pkg::ProbW-1:0]          quo_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [cpt_pkg::DivCntW-1:0]        step_q, step_d;
  logic [cpt_pkg::CountBits-1:0]      rem_q, rem_d;
  logic [cpt_pkg::CountBits-1:0]      den_q, den_d;
  logic [cpt_pkg::FracBits:0]         shf_q, shf_d;
  logic [cpt_pkg::ProbW-1:0]          quo_q, quo_d;
  logic [cpt_pkg::CountBits:0]        trial;
  logic [cpt_pkg::CountBits:0]        diff;
  logic                               ge;

  assign trial = {rem_q, shf_q[cpt_pkg::FracBits]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    shf_d  = shf_q;
    quo_d  = quo_q;
    if (start_i) begin
      // Upper dividend bits give a zero quotient since num <= den
      busy_d = 1'b1;
      step_d = cpt_pkg::DivCntW'(cpt_pkg::DivSteps - 1);
      rem_d  = {1'b0, num_i[cpt_pkg::CountBits-1:1]};
      den_d  = den_i;
      shf_d  = {num_i[0], {cpt_pkg::FracBits{1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[cpt_pkg::CountBits-1:0] : trial[cpt_pkg::CountBits-1:0];
      shf_d  = {shf_q[cpt_pkg::FracBits-1:0], 1'b0};
      quo_d  = {quo_q[cpt_pkg::ProbW-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    shf_q <= shf_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== test/conditional_probability_table_tb.sv =====
`timescale 1ns / 1ps

module conditional_probability_table_tb;

  // Unused opcode: the block must answer it with an all-zero result
  localparam logic [1:0] OpIdle = 2'd3;

  // Watchdog, well above the slowest legal run (clear sweeps dominate)
  localparam int CycleLimit  = 1_000_000;
  localparam int RandPerPass = 175;
  localparam int RandPasses  = 8;
  localparam int SettleGap   = 8;
  localparam int TailCycles  = 40;

  // Directed stimulus row: optional register write before the item, and an
  // optional typed-in result that replaces the predicted one
  typedef struct {
    bit                       set_cfg;
    logic [cpt_pkg::CfgW-1:0] cfg;
    cpt_pkg::cpt_in_t         item;
    bit                       known;
    cpt_pkg::cpt_out_t        want;
  } dir_row_t;

  // One note per item sent, consumed when the block accepts that item
  typedef struct packed {
    logic              known;
    cpt_pkg::cpt_out_t want;
  } item_note_t;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [cpt_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  cpt_pkg::cpt_in_t         in_item_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  cpt_pkg::cpt_out_t        out_item_o;

  conditional_probability_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Shadow copy of the count store, the column totals and the register
  logic [cpt_pkg::CountBits-1:0] pair_shadow  [cpt_pkg::EntDepth];
  logic [cpt_pkg::CountBits-1:0] total_shadow [cpt_pkg::ColDepth];
  logic [cpt_pkg::CfgW-1:0]      states_shadow = cpt_pkg::NumStatesRst;

  item_note_t        item_notes [$];
  cpt_pkg::cpt_out_t expected_results [$];
  dir_row_t          dir_rows [$];

  int          fails        = 0;
  int          items_taken  = 0;
  int          results_seen = 0;
  int          cfg_writes   = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // Work out the result of one item and advance the shadow state
  function automatic cpt_pkg::cpt_out_t predict_table_op(cpt_pkg::cpt_in_t it);
    cpt_pkg::cpt_out_t         r;
    logic [cpt_pkg::CfgW-1:0]  lim;
    logic [cpt_pkg::ColAw-1:0] col;
    logic [cpt_pkg::EntAw-1:0] ent;
    logic [31:0]               scaled;
    r   = '0;
    lim = (states_shadow < cpt_pkg::MaxStates) ? states_shadow
                                               : cpt_pkg::CfgW'(cpt_pkg::MaxStates);
    col = {it.node, it.hidden_state};
    ent = {col, it.visible_state};
    if (it.opcode == cpt_pkg::OP_CLEAR) begin
      foreach (pair_shadow[i]) pair_shadow[i] = '0;
      foreach (total_shadow[i]) total_shadow[i] = '0;
    end else if (it.opcode == cpt_pkg::OP_COUNT || it.opcode == cpt_pkg::OP_QUERY) begin
      if ({1'b0, it.hidden_state} >= lim || {1'b0, it.visible_state} >= lim) begin
        r.status = cpt_pkg::STS_RANGE;
      end else begin
        r.pair_count   = pair_shadow[ent];
        r.column_total = total_shadow[col];
        if (it.opcode == cpt_pkg::OP_COUNT) begin
          if (r.column_total == cpt_pkg::CntMax) begin
            r.status = cpt_pkg::STS_SAT;
          end else begin
            r.pair_count   = r.pair_count + 1'b1;
            r.column_total = r.column_total + 1'b1;
            pair_shadow[ent]  = r.pair_count;
            total_shadow[col] = r.column_total;
          end
        end else if (r.column_total != '0) begin
          scaled        = {r.pair_count, {cpt_pkg::FracBits{1'b0}}};
          r.probability = cpt_pkg::ProbW'(scaled / {16'h0, r.column_total});
        end
      end
    end
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Sample both handshakes and the register port at the rising edge
  always @(posedge clk_i) begin : monitor
    cpt_pkg::cpt_out_t pred;
    cpt_pkg::cpt_out_t want;
    item_note_t        note;
    if (cfg_we_i) states_shadow = cfg_wdata_i;
    if (in_valid_i && !in_stall_o) begin
      pred = predict_table_op(in_item_i);
      note = '0;
      if (item_notes.size() != 0) note = item_notes.pop_front();
      expected_results.push_back(note.known ? note.want : pred);
      items_taken++;
    end
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: prob %0d count %0d total %0d status %0d",
               out_item_o.probability, out_item_o.pair_count,
               out_item_o.column_total, out_item_o.status);
        fails++;
      end else begin
        want = expected_results.pop_front();
        flag_field("probability", 32'(want.probability), 32'(out_item_o.probability));
        flag_field("pair_count", 32'(want.pair_count), 32'(out_item_o.pair_count));
        flag_field("column_total", 32'(want.column_total), 32'(out_item_o.column_total));
        flag_field("status", 32'(want.status), 32'(out_item_o.status));
      end
    end
  end

  // Receiver: alternate free stretches and stall stretches of random length
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      if (out_stall_i) begin
        out_stall_i <= 1'b0;
        stall_left = $urandom_range(1, 40);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12)
                                                 : $urandom_range(1, 3);
      end
    end else begin
      stall_left--;
    end
  end

  // Offer one item at the falling edge and hold it until it is taken.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_item(input cpt_pkg::cpt_in_t it, input bit known,
                           input cpt_pkg::cpt_out_t want, input bit paced);
    int unsigned gap;
    gap = 0;
    if (paced) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 15);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_notes.push_back('{known, want});
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0 || item_notes.size() != 0) @(negedge clk_i);
    repeat (SettleGap) @(negedge clk_i);
  endtask

  task automatic write_states(input logic [cpt_pkg::CfgW-1:0] value);
    settle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_writes++;
  endtask

  task automatic add_row(input bit sc, input logic [cpt_pkg::CfgW-1:0] cv,
                         input logic [1:0] op, input logic [cpt_pkg::NodeW-1:0] n,
                         input logic [cpt_pkg::StateW-1:0] h,
                         input logic [cpt_pkg::StateW-1:0] v, input bit known,
                         input logic [cpt_pkg::ProbW-1:0] p,
                         input logic [cpt_pkg::CountBits-1:0] c,
                         input logic [cpt_pkg::CountBits-1:0] t, input logic [1:0] s);
    dir_row_t r;
    r.set_cfg = sc;
    r.cfg     = cv;
    r.item    = '{opcode: op, node: n, hidden_state: h, visible_state: v};
    r.known   = known;
    r.want    = '{probability: p, pair_count: c, column_total: t, status: s};
    dir_rows.push_back(r);
  endtask

  // Mostly in-range counts and queries; some noise, idle opcodes and clears
  function automatic cpt_pkg::cpt_in_t random_item(input logic [cpt_pkg::CfgW-1:0] ns);
    cpt_pkg::cpt_in_t it;
    int unsigned      pick;
    int unsigned      lim;
    lim  = (32'(ns) > cpt_pkg::MaxStates) ? cpt_pkg::MaxStates : 32'(ns);
    pick = $urandom_range(0, 999);
    it.node          = cpt_pkg::NodeW'($urandom);
    it.hidden_state  = cpt_pkg::StateW'($urandom);
    it.visible_state = cpt_pkg::StateW'($urandom);
    if (pick < 8) begin
      it.opcode = cpt_pkg::OP_CLEAR;
    end else if (pick < 30) begin
      it.opcode = OpIdle;
    end else if (pick < 70) begin
      it.opcode = $urandom_range(0, 1) ? cpt_pkg::OP_QUERY : cpt_pkg::OP_COUNT;
    end else begin
      it.opcode = (pick < 600) ? cpt_pkg::OP_COUNT : cpt_pkg::OP_QUERY;
      if (lim != 0) begin
        it.hidden_state  = cpt_pkg::StateW'($urandom_range(0, lim - 1));
        it.visible_state = cpt_pkg::StateW'($urandom_range(0, lim - 1));
      end
    end
    return it;
  endfunction

  initial begin : stimulus
    logic [cpt_pkg::CfgW-1:0] pass_states [RandPasses];
    logic [cpt_pkg::CfgW-1:0] cur_states;
    cpt_pkg::cpt_out_t        none;

    none = '0;
    pass_states = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd2, 5'd16, 5'd8};
    pass_states[4] = cpt_pkg::CfgW'($urandom_range(0, 31));

    // Directed rows, starting from the reset value of two states
    add_row(0, 0, cpt_pkg::OP_QUERY, 0, 0, 0,   1, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_COUNT, 0, 0, 0,   1, 0, 1, 1, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_COUNT, 0, 0, 1,   1, 0, 1, 2, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_QUERY, 0, 0, 0,   1, 32768, 1, 2, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_QUERY, 7, 1, 1,   1, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_COUNT, 7, 2, 0,   1, 0, 0, 0, cpt_pkg::STS_RANGE);
    add_row(0, 0, cpt_pkg::OP_QUERY, 0, 0, 15,  1, 0, 0, 0, cpt_pkg::STS_RANGE);
    add_row(0, 0, OpIdle,            5, 9, 3,   1, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_COUNT, 7, 1, 1,   0, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_COUNT, 7, 1, 1,   0, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_COUNT, 7, 1, 0,   0, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_QUERY, 7, 1, 1,   0, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_CLEAR, 7, 15, 15, 1, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_QUERY, 0, 0, 0,   1, 0, 0, 0, cpt_pkg::STS_OK);
    // zero states: everything is out of range
    add_row(1, 0, cpt_pkg::OP_COUNT, 0, 0, 0,   1, 0, 0, 0, cpt_pkg::STS_RANGE);
    add_row(1, 16, cpt_pkg::OP_COUNT, 7, 15, 15, 1, 0, 1, 1, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_QUERY, 7, 15, 15, 1, 65536, 1, 1, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_COUNT, 7, 15, 0,  0, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(0, 0, cpt_pkg::OP_QUERY, 7, 15, 0,  0, 0, 0, 0, cpt_pkg::STS_OK);
    // register values above sixteen clamp to sixteen
    add_row(1, 31, cpt_pkg::OP_COUNT, 3, 15, 14, 0, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(1, 17, cpt_pkg::OP_QUERY, 3, 15, 14, 0, 0, 0, 0, cpt_pkg::STS_OK);
    add_row(1, 1, cpt_pkg::OP_COUNT, 0, 1, 0,   1, 0, 0, 0, cpt_pkg::STS_RANGE);
    add_row(0, 0, cpt_pkg::OP_COUNT, 0, 0, 0,   0, 0, 0, 0, cpt_pkg::STS_OK);

    // Hold reset, release it at a falling edge, then wait out the clearing pass
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) write_states(dir_rows[i].cfg);
      send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want, 1'b1);
    end

    // Random passes, each under its own register setting
    for (int p = 0; p < RandPasses; p++) begin
      cur_states = pass_states[p];
      write_states(cur_states);
      for (int k = 0; k < RandPerPass; k++) begin
        // once, mid-way through pass 3, pause until every outstanding result is back
        if (p == 3 && k == RandPerPass / 2) settle();
        send_item(random_item(cur_states), 1'b0, none, 1'b1);
      end
    end

    // Drain, then allow for the block's own latency
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fails++;
    end

    $display("Run covered %0d items and %0d results over %0d register writes,",
             items_taken, results_seen, cfg_writes);
    $display("mixing directed edge cases, bursty random traffic, clears and output stalls.");
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
